/* design/lfc_pkg.sv */
// Package for the link frame checker: item types, result codes and constants.
`timescale 1ns / 1ps
package lfc_pkg;

  // Input item operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // Frame kind codes
  typedef enum logic [2:0] {
    KIND_LINK_ACK = 3'd0,
    KIND_LINK_NAK = 3'd1,
    KIND_CSUM_ERR = 3'd2,
    KIND_APP_MSG  = 3'd3,
    KIND_VENDOR   = 3'd4
  } kind_e;

  // Link reply codes
  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NAK  = 2'd2
  } reply_e;

  // Header and checksum constants
  localparam logic [7:0] SUM_ONE_SEED = 8'hAA;
  localparam logic [8:0] SUM_MOD      = 9'd255;
  localparam logic [7:0] HDR_LINK_ACK = 8'h06;
  localparam logic [7:0] HDR_LINK_NAK = 8'h15;
  localparam logic [7:0] VENDOR_BASE  = 8'hF0;
  localparam logic [7:0] TYPE_HI_LINK = 8'h08;
  localparam logic [7:0] TYPE_LO_ACK1 = 8'h01;
  localparam logic [7:0] TYPE_LO_ACK2 = 8'h02;

  // Span compare: declared length plus the header and checksum bytes
  localparam int unsigned SpanW = 17;
  localparam logic [SpanW-1:0] LEN_EXTRA = 17'd6;

  // Input item
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]  frame_kind;
    logic [1:0]  link_reply;
    logic [7:0]  type_high;
    logic [7:0]  type_low;
    logic [15:0] declared_length;
    logic [11:0] received_count;
  } out_item_t;

  // Running frame state shared between accumulator and classifier
  typedef struct packed {
    logic [7:0]      sum_one;
    logic [7:0]      sum_two;
    logic [3:0][7:0] hdr;
  } frame_t;

endpackage

/* design/link_frame_checker.sv */
// Top level of the link frame checker: input register, accumulator, result register.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid_i/in_ready_o  | in_item_i  (operation, data_byte)
//  out     | out | out_valid_o/out_ready_i| out_item_o (kind, reply, header, counts)
//
// One item per cycle sustained; an accepted end-of-frame item is held in the input
// register, then the accumulate/classify pass fills the result register from it. Data
// bytes keep flowing while a result waits; only an end-of-frame item holds in the input
// register until the result slot frees.
// Reset clears the valid flags and returns the frame state to its seed values.
`timescale 1ns / 1ps
module link_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lfc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lfc_pkg::out_item_t out_item_o
);
  import lfc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);

  logic            s1_valid_q, s1_valid_d;
  in_item_t        s1_item_q;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;
  logic            s1_adv, s1_is_eof;
  frame_t          frame;
  logic [CntW-1:0] count;
  out_item_t       result;

  // Advance: data items always move on, end of frame needs a free result slot
  assign s1_is_eof  = (s1_item_q.operation == OP_EOF);
  assign s1_adv     = s1_valid_q && (!s1_is_eof || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  lfc_accum #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .CntW           (CntW)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv && !s1_is_eof),
    .clear_i(s1_adv && s1_is_eof),
    .byte_i (s1_item_q.data_byte),
    .frame_o(frame),
    .count_o(count)
  );

  lfc_classify #(
    .CntW(CntW)
  ) u_classify (
    .frame_i (frame),
    .count_i (count),
    .result_o(result)
  );

  // Next-state for input and result registers
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (s1_adv && s1_is_eof) begin
      out_valid_d = 1'b1;
      out_item_d  = result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* design/lfc_accum.sv */
// Frame accumulator: header capture, saturating byte count and Fletcher sums.
`timescale 1ns / 1ps
module lfc_accum #(
  parameter int unsigned MAX_FRAME_BYTES = 2048,
  parameter int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               clear_i,
  input  logic [7:0]         byte_i,
  output lfc_pkg::frame_t    frame_o,
  output logic [CntW-1:0]    count_o
);
  import lfc_pkg::*;

  frame_t            frame_q, frame_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SpanW-1:0]  span;
  logic              summed;
  logic [8:0]        s1_raw, s2_raw;
  logic [7:0]        s1_new, s2_new;

  // Checked span covers declared length plus six bytes
  assign span = {1'b0, frame_q.hdr[2], frame_q.hdr[3]} + LEN_EXTRA;

  // Mod-255 sums: each raw sum stays below 510, so one subtract suffices
  always_comb begin
    s1_raw = {1'b0, frame_q.sum_one} + {1'b0, byte_i};
    s1_new = (s1_raw >= SUM_MOD) ? 8'(s1_raw - SUM_MOD) : s1_raw[7:0];
    s2_raw = {1'b0, frame_q.sum_two} + {1'b0, s1_new};
    s2_new = (s2_raw >= SUM_MOD) ? 8'(s2_raw - SUM_MOD) : s2_raw[7:0];
  end

  // Next frame state
  always_comb begin
    frame_d = frame_q;
    count_d = count_q;
    summed  = 1'b0;
    if (clear_i) begin
      frame_d.sum_one = SUM_ONE_SEED;
      frame_d.sum_two = 8'h00;
      frame_d.hdr     = '0;
      count_d         = '0;
    end else if (step_i && (count_q < CntW'(MAX_FRAME_BYTES))) begin
      if (count_q < CntW'(4)) begin
        frame_d.hdr[count_q[1:0]] = byte_i;
        summed = 1'b1;
      end else begin
        summed = SpanW'(count_q) < span;
      end
      if (summed) begin
        frame_d.sum_one = s1_new;
        frame_d.sum_two = s2_new;
      end
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q.sum_one <= SUM_ONE_SEED;
      frame_q.sum_two <= 8'h00;
      frame_q.hdr     <= '0;
      count_q         <= '0;
    end else begin
      frame_q <= frame_d;
      count_q <= count_d;
    end
  end

  assign frame_o = frame_q;
  assign count_o = count_q;

endmodule

/* design/lfc_classify.sv */
// Frame classifier: kind and link reply from the state at end of frame.
`timescale 1ns / 1ps
module lfc_classify #(
  parameter int unsigned CntW = 12
) (
  input  lfc_pkg::frame_t    frame_i,
  input  logic [CntW-1:0]    count_i,
  output lfc_pkg::out_item_t result_o
);
  import lfc_pkg::*;

  logic [15:0]      dl;
  logic [SpanW-1:0] span;
  logic             csum_bad;
  kind_e            kind;
  reply_e           reply;

  assign dl       = {frame_i.hdr[2], frame_i.hdr[3]};
  assign span     = {1'b0, dl} + LEN_EXTRA;
  // Short frame or non-zero sums fail the check
  assign csum_bad = (SpanW'(count_i) < span) || (frame_i.sum_one != 8'h00)
                    || (frame_i.sum_two != 8'h00);

  // Priority classification
  always_comb begin
    reply = REPLY_NONE;
    if (frame_i.hdr[0] == HDR_LINK_ACK && frame_i.hdr[1] == 8'h00) begin
      kind = KIND_LINK_ACK;
    end else if (frame_i.hdr[0] == HDR_LINK_NAK && frame_i.hdr[2] == 8'h00) begin
      kind = KIND_LINK_NAK;
    end else if (csum_bad) begin
      kind  = KIND_CSUM_ERR;
      reply = REPLY_NAK;
    end else if (frame_i.hdr[0] < VENDOR_BASE) begin
      kind = KIND_APP_MSG;
      if (frame_i.hdr[0] == TYPE_HI_LINK &&
          (frame_i.hdr[1] == TYPE_LO_ACK1 || frame_i.hdr[1] == TYPE_LO_ACK2)) begin
        reply = REPLY_ACK;
      end
    end else begin
      kind = KIND_VENDOR;
    end
  end

  always_comb begin
    result_o.frame_kind      = kind;
    result_o.link_reply      = reply;
    result_o.type_high       = frame_i.hdr[0];
    result_o.type_low        = frame_i.hdr[1];
    result_o.declared_length = dl;
    result_o.received_count  = 12'(count_i);
  end

endmodule

/* tb/link_frame_checker_tb.sv */
// Self-checking testbench for the link frame checker: directed frames, then random frames.
`timescale 1ns / 1ps
module link_frame_checker_tb;
  import lfc_pkg::*;

  localparam int unsigned FRAME_CAP    = 2048;
  localparam int          RANDOM_ITEMS = 800;
  localparam int          PLAN_ROWS    = 22;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          MAX_REPORTS  = 10;

  // One row of the directed table; fixed marks a result typed in by hand
  typedef struct packed {
    logic      op;
    logic [7:0] data;
    logic      fixed;
    out_item_t res;
  } step_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Frame tracker state
  int unsigned fl_sum_a;
  int unsigned fl_sum_b;
  int unsigned frame_bytes_seen;
  logic [7:0]  hdr_q [4];

  out_item_t  frames_due [$];
  logic [7:0] frame_bytes [$];
  step_t      plan [PLAN_ROWS];
  int         mismatch_cnt = 0;
  int         sent_items   = 0;
  int         send_calm    = 0;
  int         recv_calm    = 0;
  bit         hold_out     = 1'b0;

  link_frame_checker #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Frame state back to its seed values
  function automatic void clear_tracker();
    fl_sum_a = SUM_ONE_SEED;
    fl_sum_b = 0;
    frame_bytes_seen = 0;
    for (int i = 0; i < 4; i++) hdr_q[i] = '0;
  endfunction

  // Track one accepted item; returns 1 with the classification on end of frame
  function automatic bit predict_frame(input in_item_t item, output out_item_t res);
    int unsigned span;
    kind_e       kind;
    reply_e      reply;
    span  = {hdr_q[2], hdr_q[3]} + 32'd6;
    res   = '0;
    reply = REPLY_NONE;
    if (item.operation == OP_DATA) begin
      // bytes past the cap are dropped; bytes past the span are only counted
      if (frame_bytes_seen < FRAME_CAP) begin
        if (frame_bytes_seen < 4) hdr_q[frame_bytes_seen] = item.data_byte;
        if (frame_bytes_seen < 4 || frame_bytes_seen < span) begin
          fl_sum_a = (fl_sum_a + item.data_byte) % SUM_MOD;
          fl_sum_b = (fl_sum_b + fl_sum_a) % SUM_MOD;
        end
        frame_bytes_seen++;
      end
      return 1'b0;
    end
    if (hdr_q[0] == HDR_LINK_ACK && hdr_q[1] == '0) begin
      kind = KIND_LINK_ACK;
    end else if (hdr_q[0] == HDR_LINK_NAK && hdr_q[2] == '0) begin
      kind = KIND_LINK_NAK;
    end else if (frame_bytes_seen < span || fl_sum_a != 0 || fl_sum_b != 0) begin
      kind  = KIND_CSUM_ERR;
      reply = REPLY_NAK;
    end else if (hdr_q[0] < VENDOR_BASE) begin
      kind = KIND_APP_MSG;
      if (hdr_q[0] == TYPE_HI_LINK && (hdr_q[1] == TYPE_LO_ACK1 || hdr_q[1] == TYPE_LO_ACK2))
        reply = REPLY_ACK;
    end else begin
      kind = KIND_VENDOR;
    end
    res.frame_kind      = kind;
    res.link_reply      = reply;
    res.type_high       = hdr_q[0];
    res.type_low        = hdr_q[1];
    res.declared_length = {hdr_q[2], hdr_q[3]};
    res.received_count  = frame_bytes_seen[11:0];
    clear_tracker();
    return 1'b1;
  endfunction

  // Wait before the next item: mostly random, with calm stretches of none
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 19);
  endfunction

  function automatic step_t dat(input logic [7:0] b);
    return {OP_DATA, b, 1'b0, out_item_t'(0)};
  endfunction

  function automatic step_t eof_free(input logic [7:0] b);
    return {OP_EOF, b, 1'b0, out_item_t'(0)};
  endfunction

  function automatic step_t eof_with(input logic [7:0] b, input kind_e k, input reply_e r,
                                     input logic [7:0] hi, input logic [7:0] lo,
                                     input logic [15:0] dl, input logic [11:0] n);
    return {OP_EOF, b, 1'b1, k, r, hi, lo, dl, n};
  endfunction

  task automatic note_fail(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Offer one item and hold it until accepted; queue any result it closes
  task automatic push_item(input in_item_t item, input logic fixed, input out_item_t fixed_res);
    out_item_t guess;
    int        gap;
    gap = draw_wait(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = item;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    if (predict_frame(item, guess)) frames_due.push_back(fixed ? fixed_res : guess);
  endtask

  // Append the two check bytes that bring both sums to zero
  function automatic void seal_frame();
    int unsigned a, b, t, c1;
    a = SUM_ONE_SEED;
    b = 0;
    foreach (frame_bytes[i]) begin
      a = (a + frame_bytes[i]) % SUM_MOD;
      b = (b + a) % SUM_MOD;
    end
    t  = (SUM_MOD - b) % SUM_MOD;
    c1 = (t + SUM_MOD - a) % SUM_MOD;
    // 0xFF is congruent to zero, so it may stand in for a zero check byte
    if (c1 == 0 && $urandom_range(0, 1) == 1) c1 = 255;
    frame_bytes.push_back(8'(c1));
    frame_bytes.push_back(8'((SUM_MOD - t) % SUM_MOD));
  endfunction

  function automatic void build_good_frame(input logic [7:0] hi, input logic [7:0] lo,
                                           input logic [15:0] len);
    frame_bytes.delete();
    frame_bytes.push_back(hi);
    frame_bytes.push_back(lo);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    repeat (len) frame_bytes.push_back(8'($urandom));
    seal_frame();
  endfunction

  // Mostly well-formed frames, some link frames, some broken frames and noise
  task automatic make_random_frame();
    int         pick, n, idx;
    logic [7:0] hi, lo;
    pick = $urandom_range(0, 99);
    frame_bytes.delete();
    if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: begin
          // types 08 01, 08 02 and 08 03
          hi = TYPE_HI_LINK;
          lo = 8'($urandom_range(1, 3));
        end
        1: begin
          hi = 8'($urandom_range(0, VENDOR_BASE - 1));
          lo = 8'($urandom);
        end
        2: begin
          hi = 8'($urandom_range(VENDOR_BASE, 8'hFF));
          lo = 8'($urandom);
        end
        default: begin
          hi = 8'($urandom);
          lo = 8'($urandom);
        end
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      build_good_frame(hi, lo, 16'(n));
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        idx = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
      end else if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) void'(frame_bytes.pop_back());
      end
    end else if (pick < 70) begin
      frame_bytes.push_back(HDR_LINK_ACK);
      frame_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
    end else if (pick < 80) begin
      // nak with the length byte zero or missing altogether
      frame_bytes.push_back(HDR_LINK_NAK);
      if ($urandom_range(0, 3) != 0) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 1) begin
        frame_bytes.push_back(8'h00);
        repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(0, 10)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) push_item({OP_DATA, frame_bytes[i]}, 1'b0, '0);
    push_item({OP_EOF, 8'($urandom)}, 1'b0, '0);
  endtask

  // Compare one delivered result with the oldest one due
  task automatic check_result(input out_item_t got);
    out_item_t due;
    string     bad;
    if (frames_due.size() == 0) begin
      note_fail($sformatf("result with nothing pending: %h", got));
      return;
    end
    due = frames_due.pop_front();
    bad = "";
    if (got.frame_kind      !== due.frame_kind)      bad = {bad, " frame_kind"};
    if (got.link_reply      !== due.link_reply)      bad = {bad, " link_reply"};
    if (got.type_high       !== due.type_high)       bad = {bad, " type_high"};
    if (got.type_low        !== due.type_low)        bad = {bad, " type_low"};
    if (got.declared_length !== due.declared_length) bad = {bad, " declared_length"};
    if (got.received_count  !== due.received_count)  bad = {bad, " received_count"};
    if (bad != "")
      note_fail($sformatf("%s differ: exp %0d %0d %h %h %0d %0d, got %0d %0d %h %h %0d %0d",
                          bad, due.frame_kind, due.link_reply, due.type_high, due.type_low,
                          due.declared_length, due.received_count, got.frame_kind,
                          got.link_reply, got.type_high, got.type_low, got.declared_length,
                          got.received_count));
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : drain
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(recv_calm);
      if (hold_out) begin
        hold_out = 1'b0;
        stall    = HOLD_CYCLES;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_item_o);
    end
  end

  // Stimulus
  initial begin
    clear_tracker();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty frame, link ack, link nak, short frame, vendor frame with a trailing byte
    plan = '{
      eof_with(8'hFF, KIND_CSUM_ERR, REPLY_NAK, 8'h00, 8'h00, 16'd0, 12'd0),
      dat(HDR_LINK_ACK), dat(8'h00),
      eof_with(8'h00, KIND_LINK_ACK, REPLY_NONE, HDR_LINK_ACK, 8'h00, 16'd0, 12'd2),
      dat(HDR_LINK_NAK), dat(8'hFF), dat(8'h00),
      eof_with(8'h5A, KIND_LINK_NAK, REPLY_NONE, HDR_LINK_NAK, 8'hFF, 16'd0, 12'd3),
      dat(TYPE_HI_LINK), dat(TYPE_LO_ACK1), dat(8'h00), dat(8'h05),
      eof_with(8'h00, KIND_CSUM_ERR, REPLY_NAK, TYPE_HI_LINK, TYPE_LO_ACK1, 16'd5, 12'd4),
      dat(8'hF5), dat(8'h10), dat(8'h00), dat(8'h01), dat(8'hAB), dat(8'h91), dat(8'h11),
      dat(8'hFF), eof_free(8'hC3)
    };
    foreach (plan[i]) push_item({plan[i].op, plan[i].data}, plan[i].fixed, plan[i].res);

    // back-to-back frames into a stalled result side to fill the block
    hold_out  = 1'b1;
    send_calm = 100;
    while (sent_items < PLAN_ROWS + RANDOM_ITEMS) begin
      make_random_frame();
      send_frame();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && frames_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
design/lfc_pkg.sv
design/lfc_accum.sv
design/lfc_classify.sv
design/link_frame_checker.sv
tb/link_frame_checker_tb.sv
